// File: sv/segment_intersection_defines.svh
// assertion macros for the segment intersection block
// expects clk_i and rst_ni in the scope of the module that includes it
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// same-cycle implication
`define SI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/si_pkg.sv
// shared widths, constants and types of the segment intersection block
// no dependencies
`default_nettype none

package si_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int DW    = CW + 1;      // coordinate difference
  localparam int MW    = CW;          // difference magnitude
  localparam int PW    = 2 * DW;      // cross product term
  localparam int XW    = PW + 1;      // cross product
  localparam int TW    = 16;          // tolerance register
  localparam int NW    = 100;         // dividend width
  localparam int RW    = NW + 1;      // trial subtract width
  localparam int QW    = 34;          // quotient bits before the cap
  localparam int NSTG  = QW + 1;      // divider stages
  localparam int SW    = XW + TW + 2; // hit compare width
  localparam int AW    = CW + 6;      // saturating add width
  localparam int LANES = 3;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_L = 2;

  typedef struct packed {
    logic                 solved;
    logic                 hit;
    logic                 neg_x;
    logic                 neg_y;
    logic                 neg_l;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
  } side_t;

endpackage

`default_nettype wire

// File: sv/si_intf.sv
// beat channels of the segment intersection block: input, result, config
// depends on si_pkg
`default_nettype none

interface si_in_if;
  import si_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_start_x;
  logic signed [CW-1:0] a_start_y;
  logic signed [CW-1:0] a_end_x;
  logic signed [CW-1:0] a_end_y;
  logic signed [CW-1:0] b_start_x;
  logic signed [CW-1:0] b_start_y;
  logic signed [CW-1:0] b_end_x;
  logic signed [CW-1:0] b_end_y;
  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface si_out_if;
  import si_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 solved;
  logic                 hit;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  logic signed [CW-1:0] along_first;
  modport source (output valid, solved, hit, cross_x, cross_y, along_first,
                  input ready);
  modport sink (input valid, solved, hit, cross_x, cross_y, along_first,
                output ready);
endinterface

interface si_cfg_if;
  import si_pkg::*;
  logic          valid;
  logic          ready;
  logic [TW-1:0] edge_tolerance;
  modport source (output valid, edge_tolerance, input ready);
  modport sink (input valid, edge_tolerance, output ready);
endinterface

`default_nettype wire

// File: sv/si_front.sv
// front end: differences, cross products, sign fix, tolerance bounds,
// hit test and dividends over six register stages; depends on si_pkg, si_intf
`default_nettype none

module si_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               adv_i,
  input  wire        [si_pkg::TW-1:0]       tol_i,
  si_in_if.sink                             in_i,
  output logic                              valid_o,
  output si_pkg::side_t                     side_o,
  output logic [si_pkg::LANES-1:0][si_pkg::NW-1:0] num_o,
  output logic       [si_pkg::XW-1:0]       den_o
);
  import si_pkg::*;

  logic [5:0] v_q;

  // stage 1
  logic signed [CW-1:0] x1_q, y1_q;
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, rx1_q, ry1_q;
  // stage 2
  logic signed [CW-1:0] x2_q, y2_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [PW-1:0] p_ad_q, p_bd_q, p_rl_q, p_rm_q, p_kl_q, p_km_q;
  // stage 3
  logic signed [CW-1:0] x3_q, y3_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [XW-1:0] den3_q, nl3_q, nk3_q;
  // stage 4
  logic signed [XW-1:0] nl4_d, nk4_d, dn4_d, lmag4_d;
  logic signed [DW-1:0] dxa4_d, dya4_d;
  logic                 dneg4;
  side_t                side4_d, side4_q;
  logic signed [XW-1:0] nl4_q, nk4_q;
  logic [XW-1:0]        dn4_q, lmag4_q;
  logic [MW-1:0]        dxm4_q, dym4_q;
  // stage 5
  side_t                side5_q;
  logic signed [XW-1:0] nl5_q, nk5_q;
  logic [XW-1:0]        dn5_q, lmag5_q;
  logic [XW+TW-1:0]     dt5_q;
  logic [65:0]          pxl5_q, pyl5_q;
  logic [64:0]          pxh5_q, pyh5_q;
  // stage 6
  logic signed [SW-1:0] sl6, sk6, dts6, lob6, hib6;
  side_t                side6_d, side6_q;
  logic [LANES-1:0][NW-1:0] num6_q;
  logic [XW-1:0]        dn6_q;

  assign in_i.ready = adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], in_i.valid};
    end
  end

  always_comb begin
    dneg4   = den3_q[XW-1];
    dn4_d   = dneg4 ? -den3_q : den3_q;
    nl4_d   = dneg4 ? -nl3_q : nl3_q;
    nk4_d   = dneg4 ? -nk3_q : nk3_q;
    lmag4_d = nl3_q[XW-1] ? -nl3_q : nl3_q;
    dxa4_d  = dax3_q[DW-1] ? -dax3_q : dax3_q;
    dya4_d  = day3_q[DW-1] ? -day3_q : day3_q;
    side4_d.solved = |den3_q;
    side4_d.hit    = 1'b0;
    side4_d.neg_l  = nl4_d[XW-1];
    side4_d.neg_x  = nl4_d[XW-1] ^ dax3_q[DW-1];
    side4_d.neg_y  = nl4_d[XW-1] ^ day3_q[DW-1];
    side4_d.base_x = x3_q;
    side4_d.base_y = y3_q;
  end

  always_comb begin
    sl6  = SW'(nl5_q) <<< TW;
    sk6  = SW'(nk5_q) <<< TW;
    dts6 = $signed(SW'(dt5_q));
    lob6 = -dts6;
    hib6 = $signed(SW'({dn5_q, TW'(0)})) + dts6;
    side6_d     = side5_q;
    side6_d.hit = side5_q.solved && (sl6 >= lob6) && (sl6 <= hib6) &&
                  (sk6 >= lob6) && (sk6 <= hib6);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_q   <= in_i.a_start_x;
      y1_q   <= in_i.a_start_y;
      dax1_q <= DW'(in_i.a_end_x) - DW'(in_i.a_start_x);
      day1_q <= DW'(in_i.a_end_y) - DW'(in_i.a_start_y);
      dbx1_q <= DW'(in_i.b_end_x) - DW'(in_i.b_start_x);
      dby1_q <= DW'(in_i.b_end_y) - DW'(in_i.b_start_y);
      rx1_q  <= DW'(in_i.b_start_x) - DW'(in_i.a_start_x);
      ry1_q  <= DW'(in_i.b_start_y) - DW'(in_i.a_start_y);

      x2_q   <= x1_q;
      y2_q   <= y1_q;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      p_ad_q <= dax1_q * dby1_q;
      p_bd_q <= day1_q * dbx1_q;
      p_rl_q <= rx1_q * dby1_q;
      p_rm_q <= ry1_q * dbx1_q;
      p_kl_q <= rx1_q * day1_q;
      p_km_q <= ry1_q * dax1_q;

      x3_q   <= x2_q;
      y3_q   <= y2_q;
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      den3_q <= XW'(p_ad_q) - XW'(p_bd_q);
      nl3_q  <= XW'(p_rl_q) - XW'(p_rm_q);
      nk3_q  <= XW'(p_kl_q) - XW'(p_km_q);

      side4_q <= side4_d;
      nl4_q   <= nl4_d;
      nk4_q   <= nk4_d;
      dn4_q   <= dn4_d;
      lmag4_q <= lmag4_d;
      dxm4_q  <= dxa4_d[MW-1:0];
      dym4_q  <= dya4_d[MW-1:0];

      side5_q <= side4_q;
      nl5_q   <= nl4_q;
      nk5_q   <= nk4_q;
      dn5_q   <= dn4_q;
      lmag5_q <= lmag4_q;
      dt5_q   <= dn4_q * tol_i;
      pxl5_q  <= lmag4_q[33:0] * dxm4_q;
      pxh5_q  <= lmag4_q[XW-1:34] * dxm4_q;
      pyl5_q  <= lmag4_q[33:0] * dym4_q;
      pyh5_q  <= lmag4_q[XW-1:34] * dym4_q;

      side6_q        <= side6_d;
      dn6_q          <= dn5_q;
      num6_q[LANE_X] <= NW'(pxl5_q) + (NW'(pxh5_q) << 34);
      num6_q[LANE_Y] <= NW'(pyl5_q) + (NW'(pyh5_q) << 34);
      num6_q[LANE_L] <= NW'({lmag5_q, TW'(0)});
    end
  end

  assign valid_o = v_q[5];
  assign side_o  = side6_q;
  assign num_o   = num6_q;
  assign den_o   = dn6_q;

endmodule

`default_nettype wire

// File: sv/si_div.sv
// pipelined restoring divider, three dividends over one shared divisor,
// one quotient bit per stage plus an overflow check; depends on si_pkg
`default_nettype none

module si_div (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      adv_i,
  input  wire                                      valid_i,
  input  wire  si_pkg::side_t                      side_i,
  input  wire  [si_pkg::LANES-1:0][si_pkg::NW-1:0] num_i,
  input  wire  [si_pkg::XW-1:0]                    den_i,
  output logic                                     valid_o,
  output si_pkg::side_t                            side_o,
  output logic [si_pkg::LANES-1:0][si_pkg::QW-1:0] quo_o,
  output logic [si_pkg::LANES-1:0]                 ovf_o
);
  import si_pkg::*;

  logic [NSTG-1:0] v_q;
  side_t           side_q [NSTG];
  logic [XW-1:0]   d_q    [NSTG];
  logic [NW-1:0]   r_q    [NSTG][LANES];
  logic [QW-1:0]   qb_q   [NSTG][LANES];
  logic            ov_q   [NSTG][LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      d_q[0]    <= den_i;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_first
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[0][l]  <= num_i[l];
        qb_q[0][l] <= '0;
        ov_q[0][l] <= {1'b0, num_i[l]} >= (RW'(den_i) << QW);
      end
    end
  end

  for (genvar s = 1; s < NSTG; s++) begin : g_stg
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[s] <= side_q[s-1];
        d_q[s]    <= d_q[s-1];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] trial;
      assign trial = {1'b0, r_q[s-1][l]} - (RW'(d_q[s-1]) << (QW - s));

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          r_q[s][l]  <= trial[RW-1] ? r_q[s-1][l] : trial[NW-1:0];
          qb_q[s][l] <= trial[RW-1] ? qb_q[s-1][l]
                                    : (qb_q[s-1][l] | (QW'(1) << (QW - s)));
          ov_q[s][l] <= ov_q[s-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = qb_q[NSTG-1][l];
      ovf_o[l] = ov_q[NSTG-1][l];
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

`default_nettype wire

// File: sv/segment_intersection.sv
// throughput: one beat per cycle unless held, set by the 35-stage shared divider pipeline
// the whole pipeline holds while the output register is full and not taken
// and the last divider stage holds a beat
// reset clears all valid bits and sets edge_tolerance to 0
// top level: config register, front end, divider, saturation and output register
// depends on si_pkg, si_intf, si_front, si_div, segment_intersection_defines.svh
`default_nettype none
`include "segment_intersection_defines.svh"

module segment_intersection (
  input  wire       clk_i,
  input  wire       rst_ni,
  si_in_if.sink     in_i,
  si_out_if.source  out_o,
  si_cfg_if.sink    cfg_i
);
  import si_pkg::*;

  logic [TW-1:0]            tol_q;
  logic                     adv;
  logic                     fr_v;
  side_t                    fr_side;
  logic [LANES-1:0][NW-1:0] fr_num;
  logic [XW-1:0]            fr_den;
  logic                     div_v;
  side_t                    div_side;
  logic [LANES-1:0][QW-1:0] div_quo;
  logic [LANES-1:0]         div_ovf;
  logic                     load;
  logic                     out_v_q;
  logic                     solved_q, hit_q;
  logic signed [CW-1:0]     cx_q, cy_q, al_q;
  logic signed [CW-1:0]     cx_d, cy_d, al_d;

  function automatic logic signed [CW-1:0] add_sat(input logic signed [CW-1:0] base,
                                                   input logic neg, input logic ovf,
                                                   input logic [QW-1:0] q);
    logic [QW:0]          mag;
    logic signed [AW-1:0] off;
    logic signed [AW-1:0] s;
    mag = ovf ? {1'b1, QW'(0)} : {1'b0, q};
    off = $signed(AW'(mag));
    s   = AW'(base) + (neg ? -off : off);
    if (!s[AW-1] && (|s[AW-2:CW-1])) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (s[AW-1] && !(&s[AW-2:CW-1])) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return s[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_l(input logic neg, input logic ovf,
                                                 input logic [QW-1:0] q);
    logic big_pos;
    logic big_neg;
    big_pos = ovf || (|q[QW-1:CW-1]);
    big_neg = ovf || (|q[QW-1:CW]) || (q[CW-1] && (|q[CW-2:0]));
    if (!neg) begin
      return big_pos ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
    end
    return big_neg ? {1'b1, {(CW-1){1'b0}}} : -q[CW-1:0];
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.edge_tolerance;
    end
  end

  assign load = !out_v_q || out_o.ready;
  assign adv  = !div_v || load;

  si_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .tol_i   (tol_q),
    .in_i    (in_i),
    .valid_o (fr_v),
    .side_o  (fr_side),
    .num_o   (fr_num),
    .den_o   (fr_den)
  );

  si_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_v),
    .side_i  (fr_side),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .valid_o (div_v),
    .side_o  (div_side),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  always_comb begin
    cx_d = '0;
    cy_d = '0;
    al_d = '0;
    if (div_side.solved) begin
      cx_d = add_sat(div_side.base_x, div_side.neg_x, div_ovf[LANE_X], div_quo[LANE_X]);
      cy_d = add_sat(div_side.base_y, div_side.neg_y, div_ovf[LANE_Y], div_quo[LANE_Y]);
      al_d = sat_l(div_side.neg_l, div_ovf[LANE_L], div_quo[LANE_L]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      solved_q <= div_side.solved;
      hit_q    <= div_side.hit;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      al_q     <= al_d;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.solved      = solved_q;
  assign out_o.hit         = hit_q;
  assign out_o.cross_x     = cx_q;
  assign out_o.cross_y     = cy_q;
  assign out_o.along_first = al_q;

  `SI_ASSERT_IMP(a_stall_blocks_input, out_v_q && !out_o.ready && div_v, !in_i.ready, "input taken while pipeline is stalled")
  `SI_ASSERT_IMP(a_unsolved_zero, out_v_q && !out_o.solved, !out_o.hit && out_o.cross_x == '0 && out_o.cross_y == '0 && out_o.along_first == '0, "unsolved beat carries data")
  `SI_ASSERT_NXT(a_output_drains, out_v_q && out_o.ready && !div_v, !out_v_q, "output register not emptied")

endmodule

`default_nettype wire
